FILE: src/tlx_pkg.sv
package tlx_pkg;

  localparam logic [31:0] PRIME1 = 32'd2654435761;
  localparam logic [31:0] PRIME2 = 32'd2246822519;
  localparam logic [31:0] PRIME3 = 32'd3266489917;
  localparam logic [31:0] PRIME4 = 32'd668265263;
  localparam logic [31:0] PRIME5 = 32'd374761393;

  localparam int DATA_W = 32;

  // Request type as it arrives on the input tuser.
  typedef enum logic [1:0] {
    REQ_BODY = 2'd0,
    REQ_WORD = 2'd1,
    REQ_BYTE = 2'd2
  } req_type_t;

  // Item kind after classification by the front end.
  typedef enum logic [1:0] {
    ITEM_BODY,
    ITEM_WORD,
    ITEM_BYTE
  } item_kind_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_SEED       = 1'b0,
    CFG_TOTAL_SIZE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [DATA_W-1:0]  data;
    logic               last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_ADD,
    ST_MUL2,
    ST_FOLD,
    ST_AV1,
    ST_AV2,
    ST_OUT
  } back_state_t;

  // Lane of a body word from its position in the 8-word block.
  function automatic logic [1:0] lane_of(input logic [2:0] pos);
    logic [1:0] lane;
    case (pos)
      3'd0, 3'd3, 3'd6: lane = 2'd0;
      3'd1, 3'd4, 3'd7: lane = 2'd1;
      default:          lane = 2'd2;
    endcase
    return lane;
  endfunction

endpackage

FILE: src/tlx_front.sv
module tlx_front (
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,
  input  logic [1:0]                   in_tuser,
  input  logic                         in_tlast,
  output logic                         push_valid,
  output tlx_pkg::item_t               push_item,
  input  logic                         push_ready
);

  tlx_pkg::item_kind_t kind;

  // Type three has no meaning of its own and is hashed as a byte.
  always_comb begin
    unique case (tlx_pkg::req_type_t'(in_tuser))
      tlx_pkg::REQ_BODY: kind = tlx_pkg::ITEM_BODY;
      tlx_pkg::REQ_WORD: kind = tlx_pkg::ITEM_WORD;
      default:           kind = tlx_pkg::ITEM_BYTE;
    endcase
  end

  always_comb begin
    push_item.kind = kind;
    push_item.last = in_tlast;
    if (kind == tlx_pkg::ITEM_BYTE) begin
      push_item.data = {24'd0, in_tdata[7:0]};
    end else begin
      push_item.data = in_tdata;
    end
  end

  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

endmodule

FILE: src/tlx_queue.sv
module tlx_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  tlx_pkg::item_t  push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output tlx_pkg::item_t  pop_item,
  input  logic            pop_ready
);

  tlx_pkg::item_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

FILE: src/tlx_back.sv
module tlx_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            pop_valid,
  input  tlx_pkg::item_t  pop_item,
  output logic            pop_ready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [31:0]     out_tdata
);

  tlx_pkg::back_state_t state_r;
  tlx_pkg::back_state_t state_nxt;

  logic [31:0]         seed_r;
  logic [31:0]         total_r;
  logic [31:0]         lane_r [3];
  logic [31:0]         hash_r;
  logic [2:0]          wib_r;
  logic                folded_r;
  tlx_pkg::item_kind_t kind_r;
  logic [31:0]         data_r;
  logic                last_r;
  logic [1:0]          lane_sel_r;
  logic [31:0]         tmp_r;
  logic                out_valid_r;
  logic [31:0]         out_data_r;

  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [31:0]         mul_p;
  logic [31:0]         add_base;
  logic [31:0]         add_sum;
  logic [31:0]         add_rot;
  logic [31:0]         fold_sum;
  logic                out_free;
  logic                body_round;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign body_round = (pop_item.kind == tlx_pkg::ITEM_BODY) && !folded_r;

  // One shared multiplier, its product always lands in a register.
  always_comb begin
    mul_a = tmp_r;
    mul_b = tlx_pkg::PRIME1;
    unique case (state_r)
      tlx_pkg::ST_MUL1: begin
        mul_a = data_r;
        case (kind_r)
          tlx_pkg::ITEM_BODY: mul_b = tlx_pkg::PRIME2;
          tlx_pkg::ITEM_WORD: mul_b = tlx_pkg::PRIME3;
          default:            mul_b = tlx_pkg::PRIME5;
        endcase
      end
      tlx_pkg::ST_MUL2: begin
        mul_a = tmp_r;
        mul_b = (kind_r == tlx_pkg::ITEM_WORD) ? tlx_pkg::PRIME4 : tlx_pkg::PRIME1;
      end
      tlx_pkg::ST_AV1: begin
        mul_a = hash_r ^ (hash_r >> 15);
        mul_b = tlx_pkg::PRIME2;
      end
      tlx_pkg::ST_AV2: begin
        mul_a = tmp_r ^ (tmp_r >> 13);
        mul_b = tlx_pkg::PRIME3;
      end
      default: begin
        mul_a = tmp_r;
        mul_b = tlx_pkg::PRIME1;
      end
    endcase
    mul_p = 32'(mul_a * mul_b);
  end

  always_comb begin
    add_base = (kind_r == tlx_pkg::ITEM_BODY) ? lane_r[lane_sel_r] : hash_r;
    add_sum  = add_base + tmp_r;
    case (kind_r)
      tlx_pkg::ITEM_BODY: add_rot = {add_sum[18:0], add_sum[31:19]};
      tlx_pkg::ITEM_WORD: add_rot = {add_sum[14:0], add_sum[31:15]};
      default:            add_rot = {add_sum[20:0], add_sum[31:21]};
    endcase
    fold_sum = total_r + {lane_r[0][30:0], lane_r[0][31]}
             + {lane_r[1][24:0], lane_r[1][31:25]}
             + {lane_r[2][19:0], lane_r[2][31:20]};
  end

  always_comb begin
    state_nxt = state_r;
    pop_ready = 1'b0;
    unique case (state_r)
      tlx_pkg::ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_nxt = (body_round || folded_r) ? tlx_pkg::ST_MUL1 : tlx_pkg::ST_FOLD;
        end
      end
      tlx_pkg::ST_MUL1: state_nxt = tlx_pkg::ST_ADD;
      tlx_pkg::ST_ADD:  state_nxt = tlx_pkg::ST_MUL2;
      tlx_pkg::ST_MUL2: begin
        if (!last_r) begin
          state_nxt = tlx_pkg::ST_IDLE;
        end else if (kind_r == tlx_pkg::ITEM_BODY) begin
          state_nxt = tlx_pkg::ST_FOLD;
        end else begin
          state_nxt = tlx_pkg::ST_AV1;
        end
      end
      tlx_pkg::ST_FOLD: begin
        state_nxt = (kind_r == tlx_pkg::ITEM_BODY) ? tlx_pkg::ST_AV1 : tlx_pkg::ST_MUL1;
      end
      tlx_pkg::ST_AV1: state_nxt = tlx_pkg::ST_AV2;
      tlx_pkg::ST_AV2: state_nxt = tlx_pkg::ST_OUT;
      tlx_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = tlx_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tlx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlx_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item payload and scratch register.
  always_ff @(posedge clk) begin
    if ((state_r == tlx_pkg::ST_IDLE) && pop_valid) begin
      kind_r     <= body_round ? tlx_pkg::ITEM_BODY
                  : (pop_item.kind == tlx_pkg::ITEM_BYTE) ? tlx_pkg::ITEM_BYTE
                  : tlx_pkg::ITEM_WORD;
      data_r     <= pop_item.data;
      last_r     <= pop_item.last;
      lane_sel_r <= tlx_pkg::lane_of(wib_r);
    end
    if ((state_r == tlx_pkg::ST_MUL1) || (state_r == tlx_pkg::ST_AV1) ||
        (state_r == tlx_pkg::ST_AV2)) begin
      tmp_r <= mul_p;
    end else if (state_r == tlx_pkg::ST_ADD) begin
      tmp_r <= add_rot;
    end
    if ((state_r == tlx_pkg::ST_OUT) && out_free) begin
      out_data_r <= tmp_r ^ (tmp_r >> 16);
    end
  end

  // Hash state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= 32'd0;
      total_r     <= 32'd0;
      lane_r[0]   <= tlx_pkg::PRIME1 + tlx_pkg::PRIME2;
      lane_r[1]   <= tlx_pkg::PRIME2;
      lane_r[2]   <= 32'd0;
      hash_r      <= 32'd0;
      wib_r       <= 3'd0;
      folded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A new hash replaces the one taken in the same cycle.
      if ((state_r == tlx_pkg::ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        tlx_pkg::ST_MUL2: begin
          if (kind_r == tlx_pkg::ITEM_BODY) begin
            lane_r[lane_sel_r] <= mul_p;
            wib_r              <= wib_r + 3'd1;
          end else begin
            hash_r <= mul_p;
          end
        end
        tlx_pkg::ST_FOLD: begin
          hash_r   <= fold_sum;
          folded_r <= 1'b1;
        end
        tlx_pkg::ST_OUT: begin
          if (out_free) begin
            lane_r[0]   <= seed_r + tlx_pkg::PRIME1 + tlx_pkg::PRIME2;
            lane_r[1]   <= seed_r + tlx_pkg::PRIME2;
            lane_r[2]   <= seed_r;
            hash_r      <= 32'd0;
            wib_r       <= 3'd0;
            folded_r    <= 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (cfg_valid) begin
        if (tlx_pkg::cfg_reg_t'(cfg_index) == tlx_pkg::CFG_SEED) begin
          seed_r    <= cfg_data;
          lane_r[0] <= cfg_data + tlx_pkg::PRIME1 + tlx_pkg::PRIME2;
          lane_r[1] <= cfg_data + tlx_pkg::PRIME2;
          lane_r[2] <= cfg_data;
          hash_r    <= 32'd0;
          wib_r     <= 3'd0;
          folded_r  <= 1'b0;
        end else begin
          total_r <= cfg_data;
        end
      end
    end
  end

endmodule

FILE: src/three_lane_xxh32_hash.sv
// Three-lane XXH32-style hash of a memory region, fed as a stream of requests.
// The input channel (in_*) carries one request per handshake: in_tdata holds a
// 32-bit little-endian word or a byte in its low eight bits, in_tuser says
// whether it is a body word, a head or tail word or a single byte, and in_tlast
// marks the final request of the region. Only the final request produces an
// output: the 32-bit hash on out_tdata. The configuration channel (cfg_*) sets
// the seed (index 0, which also restarts the lanes) and the region's byte
// count (index 1); it is always ready and should only be used while idle.
// Requests are classified by the front end and held in a two-entry queue, so
// the input keeps accepting while the back end works until the queue fills.
// The back end shares one 32x32 multiplier and takes one request at a time:
// a multiply, an add and rotate and a second multiply, a lane fold once per
// region, and the avalanche multiplies on a final request. A stalled output
// holds the hash in its register; the back end then waits before restarting.
// A synchronous reset (rst_n low) clears the seed and size to zero, empties
// the queue and returns the lanes to their start values.
module three_lane_xxh32_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_word
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] hash
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic           push_valid;
  logic           push_ready;
  tlx_pkg::item_t push_item;
  logic           pop_valid;
  logic           pop_ready;
  tlx_pkg::item_t pop_item;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  tlx_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  tlx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  tlx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: sim/testbench.sv
module testbench;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned ITEM_TARGET   = 1700;

  // The block treats request type three as a byte.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_SEED,
    ROW_SIZE
  } row_kind_t;

  typedef struct packed {
    row_kind_t   op;
    logic [1:0]  kind;
    logic [31:0] value;
    logic        fin;
  } row_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] word;
    logic        fin;
  } req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  always #10 clk = ~clk;

  three_lane_xxh32_hash i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Hashes still owed by the block, oldest first.
  logic [31:0] pending_hashes [$];
  int unsigned failures = 0;
  int unsigned accepted = 0;
  // steady switches off idling on both sides; hold_request asks the
  // receiver for one long stall.
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;

  // Mirror of the hash state.
  logic [31:0] seed_now;
  logic [31:0] size_now;
  logic [31:0] hash_now;
  logic [31:0] lane_now [3];
  logic [2:0]  block_pos;
  logic        folded;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic void restart_lanes();
    lane_now[0] = seed_now + tlx_pkg::PRIME1 + tlx_pkg::PRIME2;
    lane_now[1] = seed_now + tlx_pkg::PRIME2;
    lane_now[2] = seed_now;
    hash_now    = '0;
    block_pos   = '0;
    folded      = 1'b0;
  endfunction

  function automatic void fold_lanes();
    hash_now = size_now + rotl(lane_now[0], 1) + rotl(lane_now[1], 7) +
               rotl(lane_now[2], 12);
    folded   = 1'b1;
  endfunction

  function automatic void note_register(input tlx_pkg::cfg_reg_t idx,
                                        input logic [31:0] value);
    if (idx == tlx_pkg::CFG_SEED) begin
      seed_now = value;
      restart_lanes();
    end else begin
      size_now = value;
    end
  endfunction

  // Applies one request to the mirror; returns 1 with the digest when the
  // request closes a region.
  function automatic bit absorb_request(input logic [1:0] kind, input logic [31:0] word,
                                        input logic fin, output logic [31:0] digest);
    int unsigned lane;
    logic [31:0] h;
    digest = '0;
    if (kind == tlx_pkg::REQ_BODY && !folded) begin
      lane = block_pos % 3;
      lane_now[lane] = rotl(lane_now[lane] + word * tlx_pkg::PRIME2, 13) * tlx_pkg::PRIME1;
      block_pos = block_pos + 3'd1;
    end else begin
      if (!folded) fold_lanes();
      if (kind == tlx_pkg::REQ_BODY || kind == tlx_pkg::REQ_WORD)
        hash_now = rotl(hash_now + word * tlx_pkg::PRIME3, 17) * tlx_pkg::PRIME4;
      else
        hash_now = rotl(hash_now + {24'd0, word[7:0]} * tlx_pkg::PRIME5, 11) *
                   tlx_pkg::PRIME1;
    end
    if (!fin) return 1'b0;
    if (!folded) fold_lanes();
    h = hash_now;
    h ^= h >> 15;
    h = h * tlx_pkg::PRIME2;
    h ^= h >> 13;
    h = h * tlx_pkg::PRIME3;
    h ^= h >> 16;
    digest = h;
    restart_lanes();
    return 1'b1;
  endfunction

  task automatic push_request(input logic [1:0] kind, input logic [31:0] word,
                              input logic fin);
    int unsigned gap;
    logic [31:0] digest;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    if (absorb_request(kind, word, fin, digest)) pending_hashes.push_back(digest);
    accepted++;
  endtask

  task automatic write_reg(input tlx_pkg::cfg_reg_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    note_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every owed hash, then lets requests that make no hash finish
  // inside the block before anything else happens.
  task automatic settle();
    int unsigned waited;
    in_tvalid <= 1'b0;
    waited = 0;
    while (pending_hashes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_hashes.size() != 0) begin
      $error("%0d hash results never arrived", pending_hashes.size());
      failures++;
      pending_hashes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_register_value();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // A region in the order the feeder uses: body blocks, tail words, tail and
  // head bytes, head words. One in ten is random noise instead.
  task automatic send_region();
    req_t items [$];
    req_t r;
    int unsigned body_words;
    r.fin = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        r.kind = 2'($urandom_range(0, 3));
        r.word = $urandom;
        items.push_back(r);
      end
    end else begin
      body_words = 8 * $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) body_words += $urandom_range(1, 7);
      r.kind = tlx_pkg::REQ_BODY;
      repeat (body_words) begin
        r.word = $urandom;
        items.push_back(r);
      end
      r.kind = tlx_pkg::REQ_WORD;
      repeat ($urandom_range(0, 3)) begin
        r.word = $urandom;
        items.push_back(r);
      end
      repeat ($urandom_range(0, 3) + $urandom_range(0, 3)) begin
        r.kind = ($urandom_range(0, 7) == 0) ? REQ_SPARE : tlx_pkg::REQ_BYTE;
        r.word = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 255);
        items.push_back(r);
      end
      r.kind = tlx_pkg::REQ_WORD;
      repeat ($urandom_range(0, 3)) begin
        r.word = $urandom;
        items.push_back(r);
      end
    end
    if (items.size() == 0) begin
      r.kind = tlx_pkg::REQ_BYTE;
      r.word = $urandom_range(0, 255);
      items.push_back(r);
    end
    items[items.size() - 1].fin = 1'b1;
    foreach (items[i]) push_request(items[i].kind, items[i].word, items[i].fin);
  endtask

  // Hash checker.
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hashes.size() == 0) begin
        $error("hash %h arrived with no region closed", out_tdata);
        failures++;
      end else begin
        want = pending_hashes.pop_front();
        if (out_tdata !== want) begin
          $error("hash mismatch: expected %h, actual %h", want, out_tdata);
          failures++;
        end
      end
    end
  end

  // Receiver: a random stall before each hash, or one long hold-off on request.
  initial begin
    int unsigned gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // Directed requests and register writes, each hash checked by the mirror.
  row_t directed_rows [29];

  initial begin
    int unsigned phase;
    bit          abandon;

    directed_rows = '{
      // Straight after reset: seed and size both zero.
      '{ROW_REQ,  tlx_pkg::REQ_BYTE, 32'h0000_0000, 1'b1},
      // A region of one body word: lane round, then the fold at the end.
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'hFFFF_FFFF, 1'b1},
      '{ROW_SIZE, tlx_pkg::REQ_BODY, 32'hFFFF_FFFF, 1'b0},
      '{ROW_SEED, tlx_pkg::REQ_BODY, 32'hFFFF_FFFF, 1'b0},
      // Every request kind, type three as a byte, a body word after the fold.
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'hFFFF_FFFF, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'h1234_5678, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_WORD, 32'hFFFF_FFFF, 1'b0},
      '{ROW_REQ,  REQ_SPARE,         32'hFFFF_FF80, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'hA5A5_A5A5, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BYTE, 32'h0000_00FF, 1'b1},
      // An unfinished region dropped by a seed write.
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'h0000_0001, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_WORD, 32'h0000_0002, 1'b0},
      '{ROW_SEED, tlx_pkg::REQ_BODY, 32'h9E37_79B1, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_WORD, 32'h0000_0000, 1'b1},
      // Nine body words: the lane pattern restarts with the second block.
      '{ROW_SIZE, tlx_pkg::REQ_BODY, 32'h0000_0020, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'h0123_4567, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'h89AB_CDEF, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'hFEDC_BA98, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'h7654_3210, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'h8000_0000, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'h7FFF_FFFF, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'h0000_0001, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'hDEAD_BEEF, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BODY, 32'h0F0F_0F0F, 1'b1},
      '{ROW_REQ,  tlx_pkg::REQ_WORD, 32'h0000_0000, 1'b1},
      // Back to zero registers; a byte request ignores the upper bits.
      '{ROW_SEED, tlx_pkg::REQ_BODY, 32'h0000_0000, 1'b0},
      '{ROW_SIZE, tlx_pkg::REQ_BODY, 32'h0000_0000, 1'b0},
      '{ROW_REQ,  tlx_pkg::REQ_BYTE, 32'hFFFF_FFFF, 1'b1}
    };

    seed_now = '0;
    size_now = '0;
    restart_lanes();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].op)
        ROW_REQ:
          push_request(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].fin);
        ROW_SEED: begin
          settle();
          write_reg(tlx_pkg::CFG_SEED, directed_rows[i].value);
        end
        default: begin
          settle();
          write_reg(tlx_pkg::CFG_TOTAL_SIZE, directed_rows[i].value);
        end
      endcase
    end
    settle();

    // Random phases of well-formed regions with the odd noisy one.
    phase = 0;
    while (accepted < ITEM_TARGET) begin
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // Results back up behind the long stall until the input stops too.
        hold_request = 1'b1;
        steady = 1'b1;
      end
      if ($urandom_range(0, 3) != 0)
        write_reg(tlx_pkg::CFG_TOTAL_SIZE, pick_register_value());
      if ($urandom_range(0, 2) != 0) write_reg(tlx_pkg::CFG_SEED, pick_register_value());
      repeat ($urandom_range(4, 10)) send_region();
      abandon = ($urandom_range(0, 3) == 0);
      if (abandon) begin
        repeat ($urandom_range(1, 5))
          push_request(2'($urandom_range(0, 1)), $urandom, 1'b0);
      end
      settle();
      if (abandon) write_reg(tlx_pkg::CFG_SEED, pick_register_value());
      phase++;
    end
    steady = 1'b0;
    settle();

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #(20 * 800000);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
src/tlx_pkg.sv
src/tlx_front.sv
src/tlx_queue.sv
src/tlx_back.sv
src/three_lane_xxh32_hash.sv
sim/testbench.sv
